[rtl/core/ffbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ffbt_pkg;

  localparam int POOL_BYTES_DEF = 1024;
  localparam int TAG_BYTES_DEF  = 8;

  localparam int CMD_W = 2;
  localparam int REQ_W = 10;
  localparam int OFS_W = 10;

  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // datapath micro-operations
  typedef logic [4:0] op_t;
  localparam op_t OP_IDLE     = 5'd0;
  localparam op_t OP_LOAD     = 5'd1;
  localparam op_t OP_CLEAR    = 5'd2;
  localparam op_t OP_ARD      = 5'd3;
  localparam op_t OP_AEV      = 5'd4;
  localparam op_t OP_ASTEP    = 5'd5;
  localparam op_t OP_AW1      = 5'd6;
  localparam op_t OP_AW2      = 5'd7;
  localparam op_t OP_AW3      = 5'd8;
  localparam op_t OP_AW4      = 5'd9;
  localparam op_t OP_AGRANT   = 5'd10;
  localparam op_t OP_FAIL     = 5'd11;
  localparam op_t OP_OK       = 5'd12;
  localparam op_t OP_RRD_HEAD = 5'd13;
  localparam op_t OP_REV_HEAD = 5'd14;
  localparam op_t OP_RW_HEAD  = 5'd15;
  localparam op_t OP_RW_FOOT  = 5'd16;
  localparam op_t OP_RRD_NH   = 5'd17;
  localparam op_t OP_REV_NH   = 5'd18;
  localparam op_t OP_RMERGE_N = 5'd19;
  localparam op_t OP_RRD_PF   = 5'd20;
  localparam op_t OP_REV_PF   = 5'd21;
  localparam op_t OP_RRD_PH   = 5'd22;
  localparam op_t OP_REV_PH   = 5'd23;
  localparam op_t OP_RMERGE_P = 5'd24;
  localparam op_t OP_PUSH     = 5'd25;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             clr_last;
    logic             a_broken;
    logic             a_end;
    logic             a_fit;
    logic             a_split;
    logic             r_bad_off;
    logic             r_head_bad;
    logic             r_nh_in;
    logic             r_n_merge;
    logic             r_has_prev;
    logic             r_p_ok;
    logic             fr;
    logic             out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/ffbt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ffbt_in_if import ffbt_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [REQ_W-1:0] request_size;
  logic [OFS_W-1:0] release_offset;

  modport source (output valid, command, request_size, release_offset, input ready);
  modport sink   (input valid, command, request_size, release_offset, output ready);
endinterface
`default_nettype wire

[rtl/core/ffbt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface ffbt_out_if import ffbt_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             granted;
  logic [OFS_W-1:0] payload_offset;

  modport source (output valid, granted, payload_offset, input ready);
  modport sink   (input valid, granted, payload_offset, output ready);
endinterface
`default_nettype wire

[rtl/core/ffbt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffbt_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/ffbt_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffbt_dp import ffbt_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF,
  parameter int TAG_BYTES  = TAG_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire op_t              op,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [REQ_W-1:0] in_request_size,
  input  wire logic [OFS_W-1:0] in_release_offset,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic                  out_granted,
  output logic      [OFS_W-1:0] out_payload_offset,
  output dp_stat_t              stat
);
  localparam int AW = $clog2(POOL_BYTES);
  localparam int XW = ((AW > OFS_W) ? AW : OFS_W) + 2;
  localparam int WW = AW + 1;
  localparam logic [XW-1:0] POOL_X = XW'(POOL_BYTES);
  localparam logic [XW-1:0] TAG_X  = XW'(TAG_BYTES);
  localparam logic [XW-1:0] TWO_X  = XW'(2 * TAG_BYTES);
  localparam logic [AW-1:0] FOOT0     = AW'(POOL_BYTES - TAG_BYTES);
  localparam logic [AW-1:0] CNT_LAST  = AW'(POOL_BYTES - 1);
  localparam logic [AW-1:0] INIT_SIZE = AW'(POOL_BYTES - 2 * TAG_BYTES);

  logic [CMD_W-1:0] cmd;
  logic [XW-1:0] want, rel, at, sz, head, foot, size, ns, ps;
  logic          fr;
  logic [AW-1:0] cnt;
  logic          res_g;
  logic [OFS_W-1:0] res_o;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;
  logic [XW-1:0] rd_size;
  logic          rd_free;

  logic [XW-1:0] a_next, a_rest, a_rem, a_len, a_pay, aw2_addr, aw3_addr, aw4_addr;
  logic [XW-1:0] nh, pf, ph;

  ffbt_ram #(.WIDTH(WW), .DEPTH(POOL_BYTES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_size = {{(XW-AW){1'b0}}, rdata[AW-1:0]};
  assign rd_free = rdata[AW];

  assign a_next   = at + TWO_X + sz;
  assign a_rest   = sz - want;
  assign a_rem    = a_rest - TWO_X;
  assign a_len    = stat.a_split ? want : sz;
  assign a_pay    = at + TAG_X;
  assign aw2_addr = at + TAG_X + a_len;
  assign aw3_addr = at + TWO_X + want;
  assign aw4_addr = at + TAG_X + sz;
  assign nh       = foot + TAG_X;
  assign pf       = head - TAG_X;
  assign ph       = pf - TAG_X - ps;

  always_comb begin
    stat.cmd        = cmd;
    stat.clr_last   = (cnt == CNT_LAST);
    stat.a_broken   = (a_next > POOL_X);
    stat.a_end      = (a_next >= POOL_X);
    stat.a_fit      = fr && (sz >= want);
    stat.a_split    = (a_rest >= TWO_X);
    stat.r_bad_off  = (rel < TAG_X) || (rel >= POOL_X);
    stat.r_head_bad = fr || ((rel + size + TAG_X) > POOL_X);
    stat.r_nh_in    = (nh < POOL_X);
    stat.r_n_merge  = fr && ((nh + TWO_X + ns) <= POOL_X);
    stat.r_has_prev = (head >= TAG_X);
    stat.r_p_ok     = ((ps + TAG_X) <= pf);
    stat.fr         = fr;
    stat.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = (cnt == '0 || cnt == FOOT0) ? {1'b1, INIT_SIZE} : '0;
      end
      OP_ARD:      raddr = at[AW-1:0];
      OP_AW1: begin
        we    = 1'b1;
        waddr = at[AW-1:0];
        wdata = {1'b0, a_len[AW-1:0]};
      end
      OP_AW2: begin
        we    = 1'b1;
        waddr = aw2_addr[AW-1:0];
        wdata = {1'b0, a_len[AW-1:0]};
      end
      OP_AW3: begin
        we    = 1'b1;
        waddr = aw3_addr[AW-1:0];
        wdata = {1'b1, a_rem[AW-1:0]};
      end
      OP_AW4: begin
        we    = 1'b1;
        waddr = aw4_addr[AW-1:0];
        wdata = {1'b1, a_rem[AW-1:0]};
      end
      OP_RRD_HEAD: raddr = head[AW-1:0];
      OP_RW_HEAD: begin
        we    = 1'b1;
        waddr = head[AW-1:0];
        wdata = {1'b1, size[AW-1:0]};
      end
      OP_RW_FOOT: begin
        we    = 1'b1;
        waddr = foot[AW-1:0];
        wdata = {1'b1, size[AW-1:0]};
      end
      OP_RRD_NH:   raddr = nh[AW-1:0];
      OP_RRD_PF:   raddr = pf[AW-1:0];
      OP_RRD_PH:   raddr = ph[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (op == OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (op == OP_LOAD) begin
        cnt <= '0;
      end else if (op == OP_CLEAR) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        cmd  <= in_command;
        want <= {{(XW-REQ_W){1'b0}}, in_request_size};
        rel  <= {{(XW-OFS_W){1'b0}}, in_release_offset};
        head <= {{(XW-OFS_W){1'b0}}, in_release_offset} - TAG_X;
        at   <= '0;
      end
      OP_AEV: begin
        sz <= rd_size;
        fr <= rd_free;
      end
      OP_ASTEP: at <= a_next;
      OP_AGRANT: begin
        res_g <= 1'b1;
        res_o <= a_pay[OFS_W-1:0];
      end
      OP_FAIL: begin
        res_g <= 1'b0;
        res_o <= '0;
      end
      OP_OK: begin
        res_g <= 1'b1;
        res_o <= '0;
      end
      OP_REV_HEAD: begin
        size <= rd_size;
        fr   <= rd_free;
        foot <= rel + rd_size;
      end
      OP_REV_NH: begin
        ns <= rd_size;
        fr <= rd_free;
      end
      OP_RMERGE_N: begin
        size <= size + ns + TWO_X;
        foot <= nh + TAG_X + ns;
      end
      OP_REV_PF: ps <= rd_size;
      OP_REV_PH: fr <= rd_free;
      OP_RMERGE_P: begin
        size <= ps + size + TWO_X;
        head <= ph;
      end
      OP_PUSH: begin
        out_granted        <= res_g;
        out_payload_offset <= res_o;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_wr_in_pool: assert property (@(posedge clk) disable iff (rst)
    we |-> ({{(XW-AW){1'b0}}, waddr} < POOL_X))
    else $error("tag write outside pool");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_PUSH) |-> (!out_valid || out_ready))
    else $error("result overwrites pending beat");
  a_grant_fit: assert property (@(posedge clk) disable iff (rst)
    (op == OP_AGRANT) |-> (stat.a_fit && !stat.a_broken))
    else $error("grant of chunk that does not fit");
  a_clear_step: assert property (@(posedge clk) disable iff (rst)
    (op == OP_CLEAR && !stat.clr_last) |=> (cnt == $past(cnt) + 1'b1))
    else $error("clear pass skipped an entry");
`endif
endmodule
`default_nettype wire

[rtl/core/ffbt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module ffbt_ctrl import ffbt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output op_t           op
);
  localparam logic [5:0] S_RCLEAR  = 6'd0;
  localparam logic [5:0] S_IDLE    = 6'd1;
  localparam logic [5:0] S_DISP    = 6'd2;
  localparam logic [5:0] S_ICLEAR  = 6'd3;
  localparam logic [5:0] S_ARD     = 6'd4;
  localparam logic [5:0] S_AEV     = 6'd5;
  localparam logic [5:0] S_ACHK    = 6'd6;
  localparam logic [5:0] S_AW1     = 6'd7;
  localparam logic [5:0] S_AW2     = 6'd8;
  localparam logic [5:0] S_AW3     = 6'd9;
  localparam logic [5:0] S_AW4     = 6'd10;
  localparam logic [5:0] S_AGRANT  = 6'd11;
  localparam logic [5:0] S_FAIL    = 6'd12;
  localparam logic [5:0] S_OK      = 6'd13;
  localparam logic [5:0] S_PUSH    = 6'd14;
  localparam logic [5:0] S_RRDH    = 6'd15;
  localparam logic [5:0] S_REVH    = 6'd16;
  localparam logic [5:0] S_RCHK    = 6'd17;
  localparam logic [5:0] S_RWH1    = 6'd18;
  localparam logic [5:0] S_RWF1    = 6'd19;
  localparam logic [5:0] S_NCHK0   = 6'd20;
  localparam logic [5:0] S_RRDN    = 6'd21;
  localparam logic [5:0] S_REVN    = 6'd22;
  localparam logic [5:0] S_NCHK    = 6'd23;
  localparam logic [5:0] S_RMN     = 6'd24;
  localparam logic [5:0] S_RWH2    = 6'd25;
  localparam logic [5:0] S_RWF2    = 6'd26;
  localparam logic [5:0] S_PCHK0   = 6'd27;
  localparam logic [5:0] S_RRDPF   = 6'd28;
  localparam logic [5:0] S_REVPF   = 6'd29;
  localparam logic [5:0] S_PCHK    = 6'd30;
  localparam logic [5:0] S_RRDPH   = 6'd31;
  localparam logic [5:0] S_REVPH   = 6'd32;
  localparam logic [5:0] S_PHCHK   = 6'd33;
  localparam logic [5:0] S_RMP     = 6'd34;
  localparam logic [5:0] S_RWH3    = 6'd35;
  localparam logic [5:0] S_RWF3    = 6'd36;

  logic [5:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_IDLE;
    case (state)
      S_RCLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.cmd)
          CMD_INIT:    state_next = S_ICLEAR;
          CMD_ALLOC:   state_next = S_ARD;
          CMD_RELEASE: state_next = stat.r_bad_off ? S_OK : S_RRDH;
          default:     state_next = S_FAIL;
        endcase
      end
      S_ICLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_next = S_OK;
      end
      S_ARD: begin
        op         = OP_ARD;
        state_next = S_AEV;
      end
      S_AEV: begin
        op         = OP_AEV;
        state_next = S_ACHK;
      end
      S_ACHK: begin
        if (stat.a_broken) begin
          state_next = S_FAIL;
        end else if (stat.a_fit) begin
          state_next = S_AW1;
        end else begin
          op         = OP_ASTEP;
          state_next = stat.a_end ? S_FAIL : S_ARD;
        end
      end
      S_AW1: begin
        op         = OP_AW1;
        state_next = S_AW2;
      end
      S_AW2: begin
        op         = OP_AW2;
        state_next = stat.a_split ? S_AW3 : S_AGRANT;
      end
      S_AW3: begin
        op         = OP_AW3;
        state_next = S_AW4;
      end
      S_AW4: begin
        op         = OP_AW4;
        state_next = S_AGRANT;
      end
      S_AGRANT: begin
        op         = OP_AGRANT;
        state_next = S_PUSH;
      end
      S_FAIL: begin
        op         = OP_FAIL;
        state_next = S_PUSH;
      end
      S_OK: begin
        op         = OP_OK;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          op         = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      S_RRDH: begin
        op         = OP_RRD_HEAD;
        state_next = S_REVH;
      end
      S_REVH: begin
        op         = OP_REV_HEAD;
        state_next = S_RCHK;
      end
      S_RCHK:  state_next = stat.r_head_bad ? S_OK : S_RWH1;
      S_RWH1: begin
        op         = OP_RW_HEAD;
        state_next = S_RWF1;
      end
      S_RWF1: begin
        op         = OP_RW_FOOT;
        state_next = S_NCHK0;
      end
      S_NCHK0: state_next = stat.r_nh_in ? S_RRDN : S_PCHK0;
      S_RRDN: begin
        op         = OP_RRD_NH;
        state_next = S_REVN;
      end
      S_REVN: begin
        op         = OP_REV_NH;
        state_next = S_NCHK;
      end
      S_NCHK:  state_next = stat.r_n_merge ? S_RMN : S_PCHK0;
      S_RMN: begin
        op         = OP_RMERGE_N;
        state_next = S_RWH2;
      end
      S_RWH2: begin
        op         = OP_RW_HEAD;
        state_next = S_RWF2;
      end
      S_RWF2: begin
        op         = OP_RW_FOOT;
        state_next = S_PCHK0;
      end
      S_PCHK0: state_next = stat.r_has_prev ? S_RRDPF : S_OK;
      S_RRDPF: begin
        op         = OP_RRD_PF;
        state_next = S_REVPF;
      end
      S_REVPF: begin
        op         = OP_REV_PF;
        state_next = S_PCHK;
      end
      S_PCHK:  state_next = stat.r_p_ok ? S_RRDPH : S_OK;
      S_RRDPH: begin
        op         = OP_RRD_PH;
        state_next = S_REVPH;
      end
      S_REVPH: begin
        op         = OP_REV_PH;
        state_next = S_PHCHK;
      end
      S_PHCHK: state_next = stat.fr ? S_RMP : S_OK;
      S_RMP: begin
        op         = OP_RMERGE_P;
        state_next = S_RWH3;
      end
      S_RWH3: begin
        op         = OP_RW_HEAD;
        state_next = S_RWF3;
      end
      S_RWF3: begin
        op         = OP_RW_FOOT;
        state_next = S_OK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLEAR;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

[rtl/core/first_fit_boundary_tag_allocator.sv]
// channel  dir  payload                                   beat when
// in_ch    in   command, request_size, release_offset     valid && ready
// out_ch   out  granted, payload_offset                   valid && ready
//
// Reset runs a clearing pass over the tag memory with in_ch.ready low.
// Init repeats that pass, then posts its result beat.
// Allocate: a decode step, then per chunk walked a tag read, latch and compare; a fit then
// writes the tags and posts the result; a walk that finds nothing posts a failure.
// Release: a sequence of tag reads and writes whose path depends on the neighbouring chunks.
// One item in flight; a result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_boundary_tag_allocator import ffbt_pkg::*; #(
  parameter int POOL_BYTES = POOL_BYTES_DEF,
  parameter int TAG_BYTES  = TAG_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ffbt_in_if.sink     in_ch,
  ffbt_out_if.source  out_ch
);
  op_t      op;
  dp_stat_t stat;

  ffbt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .stat    (stat),
    .op      (op)
  );

  ffbt_dp #(.POOL_BYTES(POOL_BYTES), .TAG_BYTES(TAG_BYTES)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .in_command        (in_ch.command),
    .in_request_size   (in_ch.request_size),
    .in_release_offset (in_ch.release_offset),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_granted       (out_ch.granted),
    .out_payload_offset(out_ch.payload_offset),
    .stat              (stat)
  );
endmodule
`default_nettype wire
